[rtl/core/gfbr_pkg.sv]
// Shared types and constants of the graphic panel frame buffer refresher.
`default_nettype none

package gfbr_pkg;

  localparam int ADDR_W_MAX = 12;

  localparam logic [7:0] CMD_COLUMN_ZERO = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB8;
  localparam logic [7:0] CMD_START_LINE  = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h3F;
  localparam logic [7:0] FILL_ONES       = 8'hFF;
  localparam logic [7:0] FILL_ZEROS      = 8'h00;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_TICK  = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    JOB_PIXEL = 3'd0,
    JOB_FILL  = 3'd1,
    JOB_EMIT  = 3'd2,
    JOB_READ  = 3'd3,
    JOB_INIT  = 3'd4
  } job_kind_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] x;
    logic [5:0] y;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic       chip;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       end_of_frame;
    logic       last;
  } out_item_t;

  typedef struct packed {
    job_kind_t               kind;
    logic [ADDR_W_MAX-1:0]   addr;
    logic [2:0]              bit_sel;
    logic                    color;
    logic                    chip;
    logic [7:0]              bus_byte;
    logic                    eof;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

[rtl/core/glcd_frame_buffer_refresher.sv]
// A pixel item pops with a read, then a modify-write; a refresh tick emits a command or reads a byte.
// A tick's command goes via the queue and the result register; a data byte also via the store read.
// Init emits four results on consecutive cycles; fill sweeps the store, one byte per cycle.
// After reset, busy stays high while all 2**(1 + max(1, clog2(PAGES)) + clog2(COLUMNS_PER_CHIP)) bytes
// of the frame store (1024 by default) are cleared; results cannot be stalled by the receiver.
// Top level of the two-controller graphic panel frame buffer refresher.
`default_nettype none

module glcd_frame_buffer_refresher #(
  parameter int PAGES            = 8,
  parameter int COLUMNS_PER_CHIP = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire gfbr_pkg::in_item_t item,
  output logic                    busy,
  output logic                    result_strobe,
  output gfbr_pkg::out_item_t     result
);

  localparam int AW = 1 + ((PAGES > 1) ? $clog2(PAGES) : 1) + $clog2(COLUMNS_PER_CHIP);

  logic                  push;
  gfbr_pkg::job_t        push_job;
  gfbr_pkg::job_t        head;
  gfbr_pkg::queue_stat_t qstat;
  logic                  pop;
  logic                  sweeping;

  assign busy = qstat.full || sweeping;

  gfbr_front #(
    .PAGES           (PAGES),
    .COLUMNS_PER_CHIP(COLUMNS_PER_CHIP)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(start && !busy),
    .item  (item),
    .push  (push),
    .job   (push_job)
  );

  gfbr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .stat    (qstat)
  );

  gfbr_back #(
    .AW(AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (qstat.empty),
    .pop          (pop),
    .sweeping     (sweeping),
    .result_strobe(result_strobe),
    .result       (result)
  );

endmodule

`default_nettype wire

[rtl/core/gfbr_front.sv]
// Front end: classifies accepted items into jobs and tracks the refresh position.
`default_nettype none

module gfbr_front #(
  parameter int PAGES            = 8,
  parameter int COLUMNS_PER_CHIP = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire gfbr_pkg::in_item_t item,
  output logic                   push,
  output gfbr_pkg::job_t         job
);

  localparam int CW  = $clog2(COLUMNS_PER_CHIP);
  localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int WPP = 4 + 2 * COLUMNS_PER_CHIP;
  localparam int RW  = $clog2(WPP);

  logic [PW-1:0] page;
  logic [PW-1:0] page_next;
  logic [RW-1:0] step;
  logic [RW-1:0] step_next;

  logic          pix_ok;
  logic          pix_chip;
  logic [7:0]    pix_col;
  logic [RW-1:0] data_idx;
  logic          page_end;
  logic          frame_end;

  always_comb begin
    pix_ok   = (9'(item.x) < 9'(2 * COLUMNS_PER_CHIP)) && (32'(item.y[5:3]) < PAGES);
    pix_chip = 9'(item.x) >= 9'(COLUMNS_PER_CHIP);
    pix_col  = pix_chip ? (8'(item.x) - 8'(COLUMNS_PER_CHIP)) : 8'(item.x);
    data_idx = step - RW'(4);
    page_end = step == RW'(WPP - 1);
    frame_end = page_end && (page == PW'(PAGES - 1));
  end

  always_comb begin
    push      = 1'b0;
    job       = '0;
    page_next = page;
    step_next = step;
    unique case (item.op)
      gfbr_pkg::OP_PIXEL: begin
        push        = accept && pix_ok;
        job.kind    = gfbr_pkg::JOB_PIXEL;
        job.addr    = gfbr_pkg::ADDR_W_MAX'({pix_chip, PW'(item.y[5:3]), pix_col[CW-1:0]});
        job.bit_sel = item.y[2:0];
        job.color   = item.color;
      end
      gfbr_pkg::OP_FILL: begin
        push      = accept;
        job.kind  = gfbr_pkg::JOB_FILL;
        job.color = item.color;
      end
      gfbr_pkg::OP_TICK: begin
        push    = accept;
        job.eof = frame_end;
        if (step < RW'(4)) begin
          job.kind     = gfbr_pkg::JOB_EMIT;
          job.chip     = step[0];
          job.bus_byte = step[1] ? (gfbr_pkg::CMD_PAGE_BASE | 8'(page))
                                 : gfbr_pkg::CMD_COLUMN_ZERO;
        end else begin
          job.kind = gfbr_pkg::JOB_READ;
          job.chip = data_idx[0];
          job.addr = gfbr_pkg::ADDR_W_MAX'({data_idx[0], page, CW'(data_idx >> 1)});
        end
        if (accept) begin
          if (page_end) begin
            step_next = '0;
            page_next = frame_end ? '0 : page + PW'(1);
          end else begin
            step_next = step + RW'(1);
          end
        end
      end
      gfbr_pkg::OP_INIT: begin
        push     = accept;
        job.kind = gfbr_pkg::JOB_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
      step <= '0;
    end else begin
      page <= page_next;
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gfbr_queue.sv]
// Two-entry job queue between the front end and the back end.
`default_nettype none

module gfbr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire gfbr_pkg::job_t   push_job,
  input  wire logic             pop,
  output gfbr_pkg::job_t        head,
  output gfbr_pkg::queue_stat_t stat
);

  gfbr_pkg::job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_comb begin
    head       = entry[rd_ptr];
    stat.full  = count == 2'd2;
    stat.empty = count == 2'd0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/core/gfbr_back.sv]
// Back end: owns the frame store, runs jobs and drives the result register.
`default_nettype none

module gfbr_back #(
  parameter int AW = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gfbr_pkg::job_t   head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  sweeping,
  output logic                  result_strobe,
  output gfbr_pkg::out_item_t   result
);

  typedef enum logic [4:0] {
    ST_SWEEP  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_MODIFY = 5'b00100,
    ST_SEND   = 5'b01000,
    ST_INIT   = 5'b10000
  } state_t;

  localparam int DEPTH = 2 ** AW;

  logic [7:0] mem [DEPTH];

  state_t              state;
  state_t              state_next;
  gfbr_pkg::job_t      job;
  gfbr_pkg::job_t      job_next;
  logic [AW-1:0]       sweep;
  logic [AW-1:0]       sweep_next;
  logic [7:0]          fill_byte;
  logic [7:0]          fill_byte_next;
  logic [1:0]          init_cnt;
  logic [1:0]          init_cnt_next;
  logic                strobe_next;
  gfbr_pkg::out_item_t result_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rd_data;
  logic [7:0]    bit_mask;

  always_comb begin
    sweeping = state == ST_SWEEP;
    bit_mask = 8'b1 << job.bit_sel;
  end

  always_comb begin
    state_next     = state;
    job_next       = job;
    sweep_next     = sweep;
    fill_byte_next = fill_byte;
    init_cnt_next  = init_cnt;
    strobe_next    = 1'b0;
    result_next    = result;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sweep;
    mem_wdata      = fill_byte;
    mem_re         = 1'b0;
    mem_raddr      = head.addr[AW-1:0];
    unique case (state)
      ST_SWEEP: begin
        mem_we     = 1'b1;
        sweep_next = sweep + AW'(1);
        if (&sweep) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          job_next = head;
          case (head.kind)
            gfbr_pkg::JOB_PIXEL: begin
              mem_re     = 1'b1;
              state_next = ST_MODIFY;
            end
            gfbr_pkg::JOB_FILL: begin
              fill_byte_next = head.color ? gfbr_pkg::FILL_ONES : gfbr_pkg::FILL_ZEROS;
              sweep_next     = '0;
              state_next     = ST_SWEEP;
            end
            gfbr_pkg::JOB_EMIT: begin
              strobe_next = 1'b1;
              result_next = '{head.chip, 1'b0, head.bus_byte, head.eof, 1'b1};
            end
            gfbr_pkg::JOB_READ: begin
              mem_re     = 1'b1;
              state_next = ST_SEND;
            end
            gfbr_pkg::JOB_INIT: begin
              strobe_next   = 1'b1;
              result_next   = '{1'b0, 1'b0, gfbr_pkg::CMD_START_LINE, 1'b0, 1'b0};
              init_cnt_next = 2'd1;
              state_next    = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MODIFY: begin
        mem_we     = 1'b1;
        mem_waddr  = job.addr[AW-1:0];
        mem_wdata  = job.color ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        state_next = ST_IDLE;
      end
      ST_SEND: begin
        strobe_next = 1'b1;
        result_next = '{job.chip, 1'b1, rd_data, job.eof, 1'b1};
        state_next  = ST_IDLE;
      end
      ST_INIT: begin
        strobe_next   = 1'b1;
        result_next   = '{init_cnt[1], 1'b0,
                          init_cnt[0] ? gfbr_pkg::CMD_DISPLAY_ON : gfbr_pkg::CMD_START_LINE,
                          1'b0, &init_cnt};
        init_cnt_next = init_cnt + 2'd1;
        if (&init_cnt) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    job      <= job_next;
    init_cnt <= init_cnt_next;
    result   <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep         <= '0;
      fill_byte     <= gfbr_pkg::FILL_ZEROS;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      sweep         <= sweep_next;
      fill_byte     <= fill_byte_next;
      result_strobe <= strobe_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gfbr_checker.sv]
// Port-level assertions for the frame buffer refresher and their binding.
`default_nettype none

module gfbr_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                busy,
  input wire logic                result_strobe,
  input wire gfbr_pkg::out_item_t result
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy is low right after reset.");

  a_eof_is_final_data: assert property (@(posedge clk) disable iff (rst)
      result_strobe && result.end_of_frame |-> result.last && result.is_data && result.chip)
    else $error("End of frame is not on a last right-chip data item.");

  a_data_is_last: assert property (@(posedge clk) disable iff (rst)
      result_strobe && result.is_data |-> result.last)
    else $error("A data item is not marked last.");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
      result_strobe && !result.last |=> result_strobe && !result.is_data)
    else $error("A command burst broke off before its last item.");

endmodule

bind glcd_frame_buffer_refresher gfbr_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_strobe(result_strobe),
  .result       (result)
);

`default_nettype wire
